FILE: rtl/hxfp_pkg.sv
// shared types and constants for the header, length and xor frame parser
package hxfp_pkg;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_H1    = 3'd1,
    PH_H2    = 3'd2,
    PH_H3    = 3'd3,
    PH_LEN   = 3'd4,
    PH_TOKEN = 3'd5,
    PH_BODY  = 3'd6
  } phase_t;

  localparam logic [7:0] CH_U     = 8'h55;
  localparam logic [7:0] CH_N     = 8'h4E;
  localparam logic [7:0] CH_E     = 8'h45;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_COLON = 8'h3A;

  // xor of the four header bytes and the colon
  localparam logic [7:0] HDR_XOR = CH_U ^ CH_N ^ CH_E ^ CH_R ^ CH_COLON;

  // count used when the length byte is zero
  localparam logic [7:0] LEN_WRAP = 8'hFF;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       is_payload;
    logic [7:0] payload_index;
    logic       frame_end;
    logic       checksum_ok;
    logic [7:0] frame_length;
  } result_t;

endpackage

FILE: rtl/hxfp_parse.sv
// frame state machine: header hunt, length, payload count and xor check
module hxfp_parse (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  logic [7:0]          in_byte,
  output logic                res_valid,
  output hxfp_pkg::result_t   res
);

  hxfp_pkg::phase_t phase, phase_next;
  logic [7:0] bytes_left, bytes_left_next;
  logic [7:0] running_xor, running_xor_next;
  logic [7:0] length_seen, length_seen_next;
  logic [7:0] index_count, index_count_next;
  logic       is_u;
  logic       more_payload;

  assign is_u         = (in_byte == hxfp_pkg::CH_U);
  assign more_payload = (bytes_left > 8'd1);

  always_comb begin
    phase_next       = phase;
    bytes_left_next  = bytes_left;
    running_xor_next = running_xor;
    length_seen_next = length_seen;
    index_count_next = index_count;
    // default: fall back to the hunt, checking this byte as a new start
    case (phase)
      hxfp_pkg::PH_H1: begin
        if (in_byte == hxfp_pkg::CH_N) begin
          phase_next = hxfp_pkg::PH_H2;
        end else begin
          phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
          running_xor_next = is_u ? 8'h00 : running_xor;
        end
      end
      hxfp_pkg::PH_H2: begin
        if (in_byte == hxfp_pkg::CH_E) begin
          phase_next = hxfp_pkg::PH_H3;
        end else begin
          phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
          running_xor_next = is_u ? 8'h00 : running_xor;
        end
      end
      hxfp_pkg::PH_H3: begin
        if (in_byte == hxfp_pkg::CH_R) begin
          phase_next = hxfp_pkg::PH_LEN;
        end else begin
          phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
          running_xor_next = is_u ? 8'h00 : running_xor;
        end
      end
      hxfp_pkg::PH_LEN: begin
        length_seen_next = in_byte;
        phase_next       = hxfp_pkg::PH_TOKEN;
      end
      hxfp_pkg::PH_TOKEN: begin
        if (in_byte == hxfp_pkg::CH_COLON) begin
          phase_next       = hxfp_pkg::PH_BODY;
          running_xor_next = hxfp_pkg::HDR_XOR ^ length_seen;
          bytes_left_next  = (length_seen == 8'd0) ? hxfp_pkg::LEN_WRAP : length_seen;
          index_count_next = 8'd0;
        end else begin
          phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
          running_xor_next = is_u ? 8'h00 : running_xor;
        end
      end
      hxfp_pkg::PH_BODY: begin
        if (more_payload) begin
          running_xor_next = running_xor ^ in_byte;
          bytes_left_next  = bytes_left - 8'd1;
          index_count_next = index_count + 8'd1;
        end else begin
          // checksum byte also counts as a possible start of the next frame
          bytes_left_next  = 8'd0;
          phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
          running_xor_next = is_u ? 8'h00 : running_xor;
        end
      end
      default: begin
        phase_next       = is_u ? hxfp_pkg::PH_H1 : hxfp_pkg::PH_HUNT;
        running_xor_next = is_u ? 8'h00 : running_xor;
      end
    endcase
  end

  always_comb begin
    res_valid         = (phase == hxfp_pkg::PH_BODY);
    res.data_byte     = in_byte;
    res.is_payload    = more_payload;
    res.payload_index = more_payload ? index_count : 8'd0;
    res.frame_end     = !more_payload;
    res.checksum_ok   = !more_payload && (running_xor == in_byte);
    res.frame_length  = length_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= hxfp_pkg::PH_HUNT;
      bytes_left  <= 8'd0;
      running_xor <= 8'd0;
      length_seen <= 8'd0;
      index_count <= 8'd0;
    end else if (step) begin
      phase       <= phase_next;
      bytes_left  <= bytes_left_next;
      running_xor <= running_xor_next;
      length_seen <= length_seen_next;
      index_count <= index_count_next;
    end
  end

endmodule

FILE: rtl/header_length_xor_frame_parser.sv
// top level: input register, frame parser and result register
//
// Byte-stream frame parser. Bytes enter on in_valid/in_ready/in_byte, one
// transaction per byte. The parser hunts for the header U N E R, takes a
// length byte and a ':' and then reports each payload byte with its index,
// followed by one frame-end result carrying the checksum byte and whether
// it matched the xor of all earlier frame bytes. Bytes outside a frame give
// no result. Results leave on out_valid/out_ready with one port per field.
// An accepted byte waits in the input register and its result is then
// registered in the output register. Throughput: one byte per cycle while
// the receiver takes results, with the state update between the registers.
// When the receiver stalls the result register holds its value; the input
// register still takes one more byte, then in_ready drops until the result
// is taken. Reset (rst, synchronous) empties both registers and returns the
// parser to the hunt for 'U' with length, count and xor cleared.
module header_length_xor_frame_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] data_byte,
  output logic       is_payload,
  output logic [7:0] payload_index,
  output logic       frame_end,
  output logic       checksum_ok,
  output logic [7:0] frame_length
);

  logic              in_full;
  logic [7:0]        in_data;
  logic              out_free;
  logic              process;
  logic              res_valid;
  hxfp_pkg::result_t res;
  hxfp_pkg::result_t out_res;

  assign out_free = !out_valid || out_ready;
  assign process  = in_full && out_free;
  assign in_ready = !in_full || process;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_full <= 1'b1;
    end else if (process) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_data <= in_byte;
    end
  end

  hxfp_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .step      (process),
    .in_byte   (in_data),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= process && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && process && res_valid) begin
      out_res <= res;
    end
  end

  assign data_byte     = out_res.data_byte;
  assign is_payload    = out_res.is_payload;
  assign payload_index = out_res.payload_index;
  assign frame_end     = out_res.frame_end;
  assign checksum_ok   = out_res.checksum_ok;
  assign frame_length  = out_res.frame_length;

  // a result is either a payload byte or a frame end, never both
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (is_payload != frame_end))
    else $error("result is not exactly one of payload and frame end");

  // payload index stays inside the announced length
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && is_payload) |->
      ((frame_length == 8'd0) ||
       (({1'b0, payload_index} + 9'd1) < {1'b0, frame_length})))
    else $error("payload index beyond frame length");

  // frame end carries index zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && frame_end) |-> (payload_index == 8'd0))
    else $error("frame end with nonzero index");

  // a byte waiting in the input register is not dropped while stalled
  assert property (@(posedge clk) disable iff (rst)
    (in_full && !process) |=> (in_full && $stable(in_data)))
    else $error("input byte lost during stall");

endmodule
